>>> src/roi_window_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the search-window tracker
// Shared concurrent-check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ROI_WINDOW_TRACKER_CORE_MACROS_SVH
`define ROI_WINDOW_TRACKER_CORE_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define ROI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ROI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/roi_pkg.sv
// ----------------------------------------------------------------------------
// roi_pkg
// Widths, reset values, register indexes, states and shared types of the
// search-window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package roi_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int COORD_W    = 16;
  localparam int SUM_W      = COORD_W + 2;
  localparam int LEN_W      = 18;
  localparam int RAD_W      = 2 * LEN_W;
  localparam int EDGE_W     = 12;
  localparam int SCALE_W    = 4;
  localparam int MISS_W     = 16;
  localparam int HALF_W     = 23;
  localparam int VAL_W      = HALF_W + 2;
  localparam int MUL_W      = SUM_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int PIX_SHIFT  = FRAC_BITS + 2;
  localparam int MINH_SHIFT = FRAC_BITS + 1;
  localparam int PIX_W      = VAL_W - 1 - PIX_SHIFT;
  localparam int CNT_W      = $clog2(LEN_W);
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int N_CORNER   = 8;

  localparam logic [EDGE_W-1:0]  RST_FRAME_W  = EDGE_W'(1280);
  localparam logic [EDGE_W-1:0]  RST_FRAME_H  = EDGE_W'(1024);
  localparam logic [SCALE_W-1:0] RST_W_SCALE  = SCALE_W'(8);
  localparam logic [SCALE_W-1:0] RST_H_SCALE  = SCALE_W'(4);
  localparam logic [EDGE_W-1:0]  RST_MIN_H    = EDGE_W'(50);
  localparam logic [MISS_W-1:0]  RST_LOSS_LIM = MISS_W'(10);
  localparam logic [MISS_W-1:0]  MISS_MAX     = '1;

  typedef enum logic [2:0] {
    REG_FRAME_W  = 3'd0,
    REG_FRAME_H  = 3'd1,
    REG_W_SCALE  = 3'd2,
    REG_H_SCALE  = 3'd3,
    REG_MIN_H    = 3'd4,
    REG_LOSS_LIM = 3'd5
  } roi_reg_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_SUM  = 13'h0002,
    S_SQW0 = 13'h0004,
    S_SQW1 = 13'h0008,
    S_RTW  = 13'h0010,
    S_SQH0 = 13'h0020,
    S_SQH1 = 13'h0040,
    S_RTH  = 13'h0080,
    S_SCW  = 13'h0100,
    S_SCH  = 13'h0200,
    S_EDX  = 13'h0400,
    S_EDY  = 13'h0800,
    S_DONE = 13'h1000
  } roi_state_t;

  // Status of the shared square-root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } roi_sq_stat_t;

endpackage

`default_nettype wire

>>> src/roi_isqrt.sv
// ----------------------------------------------------------------------------
// roi_isqrt
// Digit-by-digit floor square root, one result bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [roi_pkg::RAD_W-1:0] radicand,
  output roi_pkg::roi_sq_stat_t          stat,
  output logic [roi_pkg::LEN_W-1:0]      root
);
  import roi_pkg::*;

  logic [RAD_W-1:0]   rad_r;
  logic [LEN_W+1:0]   rem_r;
  logic [LEN_W-1:0]   root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [LEN_W+3:0]   rem_sh;
  logic [LEN_W+3:0]   trial;
  logic [LEN_W+3:0]   rem_sub;
  logic               fits;

  // Bring down the next two radicand bits and try appending a one.
  always_comb begin
    rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    fits    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(LEN_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LEN_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sub[LEN_W+1:0] : rem_sh[LEN_W+1:0];
      root_r <= {root_r[LEN_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

`default_nettype wire

>>> src/roi_edge.sv
// ----------------------------------------------------------------------------
// roi_edge
// Forms the two box edges of one axis, truncates them to whole pixels and
// clamps them to the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_edge (
  input  wire logic signed [roi_pkg::SUM_W-1:0] center,
  input  wire logic [roi_pkg::HALF_W-1:0]       half,
  input  wire logic [roi_pkg::EDGE_W-1:0]       lim,
  output logic [roi_pkg::EDGE_W-1:0]            lo,
  output logic [roi_pkg::EDGE_W-1:0]            hi
);
  import roi_pkg::*;

  function automatic logic [EDGE_W-1:0] to_pix(input logic signed [VAL_W-1:0] v,
                                               input logic [EDGE_W-1:0] l);
    logic [PIX_W-1:0] p;
    p = v[VAL_W-2:PIX_SHIFT];
    if (v[VAL_W-1] || (v == '0)) begin
      return '0;
    end else if (p > PIX_W'(l)) begin
      return l;
    end else begin
      return p[EDGE_W-1:0];
    end
  endfunction

  logic signed [VAL_W-1:0] c_ext;
  logic signed [VAL_W-1:0] h_ext;

  always_comb begin
    c_ext = VAL_W'(center);
    h_ext = $signed(VAL_W'(half));
    lo    = to_pix(c_ext - h_ext, lim);
    hi    = to_pix(c_ext + h_ext, lim);
  end

endmodule

`default_nettype wire

>>> src/roi_window_tracker_core.sv
// ----------------------------------------------------------------------------
// roi_window_tracker_core
// Search-window tracker: turns detected target corners into a clamped
// search window and falls back to the full frame after repeated misses.
// ----------------------------------------------------------------------------
// A request transfer (in_tuser = 0) goes straight to the done state,
// returns the current window through the output register and counts a
// miss; once the miss count is above loss_limit, or while no window
// exists, it returns the full frame with full_frame set and clears the
// count. A feedback transfer (in_tuser = 1) carries four corners in Q12.4
// pixels; its run time is set mostly by the shared square-root unit,
// which delivers one root bit per cycle and runs twice (target width,
// then height), each time fed by two squarings on the single 19 x 19
// multiplier; the same multiplier then applies the scale registers.
// in_tready is high only while the sequencer is idle, so one item is
// worked on at a time, and the result sits in an output register, so a
// new item can be taken while the previous result still waits. The
// configuration registers sit on an APB-style port at byte addresses 0, 4,
// 8, 12, 16 and 20, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_window_tracker_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input stream.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // tdata: corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
  //        corner2_y, corner3_x, corner3_y (16 bits signed each, from bit 0)
  input  wire logic [127:0]               in_tdata,
  // tuser: kind (bit 0; 0 = request, 1 = feedback)
  input  wire logic                       in_tuser,
  // Result stream.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // tdata: win_left [11:0], win_top [23:12], win_right [35:24],
  //        win_bottom [47:36], misses [63:48]
  output logic [63:0]                     out_tdata,
  // tuser: full_frame (bit 0)
  output logic                            out_tuser,
  // Configuration port.
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [roi_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [roi_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [roi_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import roi_pkg::*;

`include "roi_window_tracker_core_macros.svh"

  // Configuration registers.
  logic [EDGE_W-1:0]  frame_w_r;
  logic [EDGE_W-1:0]  frame_h_r;
  logic [SCALE_W-1:0] w_scale_r;
  logic [SCALE_W-1:0] h_scale_r;
  logic [EDGE_W-1:0]  min_h_r;
  logic [MISS_W-1:0]  loss_lim_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  // Tracker state.
  roi_state_t         state_r, state_nxt;
  logic               have_r;
  logic [MISS_W-1:0]  miss_r;
  logic               full_r;
  logic [EDGE_W-1:0]  left_r, top_r, right_r, bottom_r;

  // Working registers of a feedback item.
  logic signed [COORD_W-1:0] crn_r [N_CORNER];
  logic signed [SUM_W-1:0]   sx_r, sy_r, wx_r, wy_r, hx_r, hy_r;
  logic [RAD_W-1:0]          acc_r;
  logic [LEN_W-1:0]          lw_r, lh_r;
  logic [HALF_W-1:0]         hw_r, hh_r;

  // Output register.
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic               out_full_r;

  // Shared multiplier, root unit and edge unit.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     sq_start;
  logic [RAD_W-1:0]         sq_rad;
  roi_sq_stat_t             sq_stat;
  logic [LEN_W-1:0]         sq_root;
  logic [LEN_W-1:0]         minh_len;
  logic [LEN_W-1:0]         lh_eff;
  logic signed [SUM_W-1:0]  edge_c;
  logic [HALF_W-1:0]        edge_h;
  logic [EDGE_W-1:0]        edge_lim;
  logic [EDGE_W-1:0]        edge_lo, edge_hi;

  logic in_fire;
  logic out_free;

  // --------------------------------------------------------------------------
  // Configuration port: a write lands on the access cycle; pready is tied high.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r  <= RST_FRAME_W;
      frame_h_r  <= RST_FRAME_H;
      w_scale_r  <= RST_W_SCALE;
      h_scale_r  <= RST_H_SCALE;
      min_h_r    <= RST_MIN_H;
      loss_lim_r <= RST_LOSS_LIM;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_W:  frame_w_r  <= cfg_pwdata[EDGE_W-1:0];
        REG_FRAME_H:  frame_h_r  <= cfg_pwdata[EDGE_W-1:0];
        REG_W_SCALE:  w_scale_r  <= cfg_pwdata[SCALE_W-1:0];
        REG_H_SCALE:  h_scale_r  <= cfg_pwdata[SCALE_W-1:0];
        REG_MIN_H:    min_h_r    <= cfg_pwdata[EDGE_W-1:0];
        REG_LOSS_LIM: loss_lim_r <= cfg_pwdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_W:  cfg_prdata = DATA_W'(frame_w_r);
      REG_FRAME_H:  cfg_prdata = DATA_W'(frame_h_r);
      REG_W_SCALE:  cfg_prdata = DATA_W'(w_scale_r);
      REG_H_SCALE:  cfg_prdata = DATA_W'(h_scale_r);
      REG_MIN_H:    cfg_prdata = DATA_W'(min_h_r);
      REG_LOSS_LIM: cfg_prdata = DATA_W'(loss_lim_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshakes.
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Shared multiplier: squares of the edge vectors, then length times scale.
  // --------------------------------------------------------------------------
  assign minh_len = LEN_W'({min_h_r, MINH_SHIFT'(0)});
  assign lh_eff   = (lh_r < minh_len) ? minh_len : lh_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQW0: begin mul_a = MUL_W'(wx_r); mul_b = MUL_W'(wx_r); end
      S_SQW1: begin mul_a = MUL_W'(wy_r); mul_b = MUL_W'(wy_r); end
      S_SQH0: begin mul_a = MUL_W'(hx_r); mul_b = MUL_W'(hx_r); end
      S_SQH1: begin mul_a = MUL_W'(hy_r); mul_b = MUL_W'(hy_r); end
      S_SCW: begin
        mul_a = $signed(MUL_W'(lw_r));
        mul_b = $signed(MUL_W'(w_scale_r));
      end
      S_SCH: begin
        mul_a = $signed(MUL_W'(lh_eff));
        mul_b = $signed(MUL_W'(h_scale_r));
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // The second square completes the radicand and starts the root directly.
  assign sq_start = (state_r == S_SQW1) || (state_r == S_SQH1);
  assign sq_rad   = acc_r + prod[RAD_W-1:0];

  roi_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  // One edge unit serves the x axis, then the y axis.
  always_comb begin
    if (state_r == S_EDY) begin
      edge_c   = sy_r;
      edge_h   = hh_r;
      edge_lim = frame_h_r;
    end else begin
      edge_c   = sx_r;
      edge_h   = hw_r;
      edge_lim = frame_w_r;
    end
  end

  roi_edge u_edge (
    .center (edge_c),
    .half   (edge_h),
    .lim    (edge_lim),
    .lo     (edge_lo),
    .hi     (edge_hi)
  );

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = in_tuser ? S_SUM : S_DONE;
      S_SUM:  state_nxt = S_SQW0;
      S_SQW0: state_nxt = S_SQW1;
      S_SQW1: state_nxt = S_RTW;
      S_RTW:  if (sq_stat.done) state_nxt = S_SQH0;
      S_SQH0: state_nxt = S_SQH1;
      S_SQH1: state_nxt = S_RTH;
      S_RTH:  if (sq_stat.done) state_nxt = S_SCW;
      S_SCW:  state_nxt = S_SCH;
      S_SCH:  state_nxt = S_EDX;
      S_EDX:  state_nxt = S_EDY;
      S_EDY:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, window flag, miss count, stored window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      have_r   <= 1'b0;
      miss_r   <= '0;
      full_r   <= 1'b0;
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= RST_FRAME_W;
      bottom_r <= RST_FRAME_H;
    end else begin
      state_r <= state_nxt;
      if (in_fire && !in_tuser) begin
        if (!have_r || (miss_r > loss_lim_r)) begin
          // Target lost: fall back to the whole frame.
          have_r   <= 1'b0;
          miss_r   <= '0;
          full_r   <= 1'b1;
          left_r   <= '0;
          top_r    <= '0;
          right_r  <= frame_w_r;
          bottom_r <= frame_h_r;
        end else begin
          full_r <= 1'b0;
          if (miss_r != MISS_MAX) begin
            miss_r <= miss_r + 1'b1;
          end
        end
      end
      if (state_r == S_EDX) begin
        left_r  <= edge_lo;
        right_r <= edge_hi;
      end
      if (state_r == S_EDY) begin
        top_r    <= edge_lo;
        bottom_r <= edge_hi;
        have_r   <= 1'b1;
        miss_r   <= '0;
        full_r   <= 1'b0;
      end
    end
  end

  // Datapath registers of a feedback item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < N_CORNER; i++) begin
        crn_r[i] <= $signed(in_tdata[i*COORD_W +: COORD_W]);
      end
    end
    if (state_r == S_SUM) begin
      // Corner sum gives four times the centre; the differences of the corner
      // sums of opposite edges give doubled width and height vectors.
      sx_r <= SUM_W'(crn_r[0]) + SUM_W'(crn_r[2]) + SUM_W'(crn_r[4]) + SUM_W'(crn_r[6]);
      sy_r <= SUM_W'(crn_r[1]) + SUM_W'(crn_r[3]) + SUM_W'(crn_r[5]) + SUM_W'(crn_r[7]);
      wx_r <= SUM_W'(crn_r[2]) + SUM_W'(crn_r[4]) - SUM_W'(crn_r[0]) - SUM_W'(crn_r[6]);
      wy_r <= SUM_W'(crn_r[3]) + SUM_W'(crn_r[5]) - SUM_W'(crn_r[1]) - SUM_W'(crn_r[7]);
      hx_r <= SUM_W'(crn_r[4]) + SUM_W'(crn_r[6]) - SUM_W'(crn_r[2]) - SUM_W'(crn_r[0]);
      hy_r <= SUM_W'(crn_r[5]) + SUM_W'(crn_r[7]) - SUM_W'(crn_r[3]) - SUM_W'(crn_r[1]);
    end
    if ((state_r == S_SQW0) || (state_r == S_SQH0)) begin
      acc_r <= prod[RAD_W-1:0];
    end
    if ((state_r == S_RTW) && sq_stat.done) begin
      lw_r <= sq_root;
    end
    if ((state_r == S_RTH) && sq_stat.done) begin
      lh_r <= sq_root;
    end
    if (state_r == S_SCW) begin
      hw_r <= {prod[HALF_W-2:0], 1'b0};
    end
    if (state_r == S_SCH) begin
      hh_r <= {prod[HALF_W-2:0], 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= {miss_r, bottom_r, right_r, top_r, left_r};
      out_full_r <= full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  `ROI_ASSERT_IMPL(a_root_done_in_wait, sq_stat.done, (state_r == S_RTW) || (state_r == S_RTH), "square root finished outside a root wait state")
  `ROI_ASSERT_IMPL(a_full_frame_window, out_tvalid && out_tuser, (out_tdata[11:0] == '0) && (out_tdata[23:12] == '0) && (out_tdata[63:48] == '0), "full-frame result with nonzero origin or miss count")
  `ROI_ASSERT_NEXT(a_feedback_sets_window, state_r == S_EDY, have_r && (miss_r == '0) && !full_r, "feedback did not establish a window")
  `ROI_ASSERT_IMPL(a_no_root_restart, sq_start, !sq_stat.busy, "square root restarted while busy")

endmodule

`default_nettype wire

>>> verif/tb_roi_window_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roi_window_tracker_core
// Self-checking bench for the search-window tracker: a short table of
// directed transfers and register writes, then random phases, each under
// its own register setting. Each result is checked field by field against
// a typed row value or an in-bench model of the window and miss-counter
// logic. A final run counts misses at the largest loss limit, then lowers it.
// ----------------------------------------------------------------------------

module tb_roi_window_tracker_core;
  import roi_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 4;
  // The drain slack is sized to cover a feedback result that is still
  // being worked on.
  localparam int DRAIN_CYCLES    = 64;
  localparam int IDLE_SETTLE     = 4;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES     = 400;
  localparam int TOP_LIM_REQUESTS = 40;
  // The slowest correct run is about 1400 transfers, each bounded by the
  // feedback latency, the longest sender gap and receiver stall, plus the
  // long hold-off. The limit leaves a margin of several times over that.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_FEEDBACK = 1'b1;

  // Register indexes past the last register. Writes to them must be ignored.
  localparam logic [2:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [2:0] UNMAPPED_REG_HI = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef enum logic [1:0] {
    PICK_MIN  = 2'd0,
    PICK_MAX  = 2'd1,
    PICK_ZERO = 2'd2,
    PICK_ONES = 2'd3
  } corner_pick_t;

  // One result transfer, unpacked from out_tdata and out_tuser.
  typedef struct packed {
    logic [EDGE_W-1:0] w_left;
    logic [EDGE_W-1:0] w_top;
    logic [EDGE_W-1:0] w_right;
    logic [EDGE_W-1:0] w_bottom;
    logic              full;
    logic [MISS_W-1:0] misses;
  } win_result_t;

  // One input transfer. A row of the directed table may carry its expected
  // result typed in; otherwise the model supplies it.
  typedef struct {
    logic        kind;
    logic [127:0] corners;
    bit          has_typed;
    win_result_t typed_res;
  } tx_item_t;

  typedef struct {
    row_op_t     op;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    tx_item_t    item;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                in_tvalid;
  logic                in_tready;
  logic [127:0]        in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [63:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  roi_window_tracker_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Model copy of the registers and of the tracker state.
  // --------------------------------------------------------------------------
  logic [EDGE_W-1:0]  reg_frame_w;
  logic [EDGE_W-1:0]  reg_frame_h;
  logic [SCALE_W-1:0] reg_w_scale;
  logic [SCALE_W-1:0] reg_h_scale;
  logic [EDGE_W-1:0]  reg_min_h;
  logic [MISS_W-1:0]  reg_loss_lim;

  bit                 win_valid;
  logic [MISS_W-1:0]  miss_cnt;
  logic [EDGE_W-1:0]  edge_l;
  logic [EDGE_W-1:0]  edge_t;
  logic [EDGE_W-1:0]  edge_r;
  logic [EDGE_W-1:0]  edge_b;

  // Transfers waiting to be offered, and results waiting to arrive.
  tx_item_t    send_q[$];
  win_result_t window_q[$];
  dir_row_t    directed_rows[$];

  bit          sending;
  bit          gaps_on;
  bit          rx_stalls_on;
  bit          hold_req;

  int          errors;
  int unsigned cycle_count;
  int          n_feedback;
  int          n_request;
  int          n_fallback;
  int          n_results;
  int          n_cfg_writes;

  // --------------------------------------------------------------------------
  // Arithmetic of the model.
  // --------------------------------------------------------------------------

  // Floor square root, one result bit per step from the top, 18 bits.
  function automatic longint unsigned floor_sqrt36(input longint unsigned a);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = LEN_W - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= a) root = trial;
    end
    return root;
  endfunction

  // Quarter-Q4 value to whole pixels: truncated toward zero, then clamped.
  function automatic logic [EDGE_W-1:0] clamp_pixel(input longint v,
                                                    input logic [EDGE_W-1:0] lim);
    longint unsigned pix;
    if (v <= 0) return '0;
    pix = longint'(v) >> PIX_SHIFT;
    return (pix > lim) ? lim : pix[EDGE_W-1:0];
  endfunction

  // Advances the model by one accepted transfer and returns its result.
  function automatic win_result_t predict_window(input logic kind,
                                                 input logic [127:0] c);
    longint          xs [4];
    longint          ys [4];
    longint          sx, sy, wx, wy, hx, hy, hw, hh;
    longint unsigned lw, lh, minh;
    win_result_t     r;
    r.full = 1'b0;
    if (kind == KIND_FEEDBACK) begin
      for (int k = 0; k < 4; k++) begin
        xs[k] = longint'($signed(c[32*k +: 16]));
        ys[k] = longint'($signed(c[32*k + 16 +: 16]));
      end
      sx = xs[0] + xs[1] + xs[2] + xs[3];
      sy = ys[0] + ys[1] + ys[2] + ys[3];
      // Doubled edge vectors across the width and the height of the target.
      wx = xs[1] + xs[2] - xs[0] - xs[3];
      wy = ys[1] + ys[2] - ys[0] - ys[3];
      hx = xs[2] + xs[3] - xs[1] - xs[0];
      hy = ys[2] + ys[3] - ys[1] - ys[0];
      lw = floor_sqrt36(longint'(wx * wx + wy * wy));
      lh = floor_sqrt36(longint'(hx * hx + hy * hy));
      minh = longint'(reg_min_h) << MINH_SHIFT;
      if (lh < minh) lh = minh;
      hw = longint'(2 * lw * reg_w_scale);
      hh = longint'(2 * lh * reg_h_scale);
      edge_l    = clamp_pixel(sx - hw, reg_frame_w);
      edge_r    = clamp_pixel(sx + hw, reg_frame_w);
      edge_t    = clamp_pixel(sy - hh, reg_frame_h);
      edge_b    = clamp_pixel(sy + hh, reg_frame_h);
      win_valid = 1'b1;
      miss_cnt  = '0;
    end else if (!win_valid || miss_cnt > reg_loss_lim) begin
      // Target lost or never seen: fall back to the whole frame.
      miss_cnt  = '0;
      win_valid = 1'b0;
      edge_l    = '0;
      edge_t    = '0;
      edge_r    = reg_frame_w;
      edge_b    = reg_frame_h;
      r.full    = 1'b1;
    end else if (miss_cnt != MISS_MAX) begin
      miss_cnt = miss_cnt + 1'b1;
    end
    r.w_left   = edge_l;
    r.w_top    = edge_t;
    r.w_right  = edge_r;
    r.w_bottom = edge_b;
    r.misses   = miss_cnt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Small builders for stimulus and expected values.
  // --------------------------------------------------------------------------

  // Packs four corners in Q12.4, saturated to 16 bits, corner0_x lowest.
  function automatic logic [127:0] corner_word(input int x0, input int y0,
                                               input int x1, input int y1,
                                               input int x2, input int y2,
                                               input int x3, input int y3);
    int           v [8];
    logic [127:0] w;
    v = '{x0, y0, x1, y1, x2, y2, x3, y3};
    for (int k = 0; k < 8; k++) begin
      if (v[k] > 32767) v[k] = 32767;
      if (v[k] < -32768) v[k] = -32768;
      w[16*k +: 16] = v[k][15:0];
    end
    return w;
  endfunction

  function automatic win_result_t win_res(input int l, input int t, input int r,
                                          input int b, input bit full,
                                          input int misses);
    win_result_t res;
    res.w_left   = l[EDGE_W-1:0];
    res.w_top    = t[EDGE_W-1:0];
    res.w_right  = r[EDGE_W-1:0];
    res.w_bottom = b[EDGE_W-1:0];
    res.full     = full;
    res.misses   = misses[MISS_W-1:0];
    return res;
  endfunction

  function automatic dir_row_t item_row(input logic kind, input logic [127:0] w);
    dir_row_t row;
    row.op             = ROW_ITEM;
    row.reg_idx        = '0;
    row.reg_val        = '0;
    row.item.kind      = kind;
    row.item.corners   = w;
    row.item.has_typed = 1'b0;
    row.item.typed_res = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic kind, input logic [127:0] w,
                                         input win_result_t res);
    dir_row_t row;
    row                = item_row(kind, w);
    row.item.has_typed = 1'b1;
    row.item.typed_res = res;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
    dir_row_t row;
    row         = item_row(KIND_REQUEST, '0);
    row.op      = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic void push_item(input logic kind, input logic [127:0] w);
    tx_item_t it;
    it.kind      = kind;
    it.corners   = w;
    it.has_typed = 1'b0;
    it.typed_res = '0;
    send_q.push_back(it);
  endfunction

  function automatic void check_field(input string what, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. A write is a setup phase followed by an access
  // phase. Each mapped register is read back at once and must hold the low
  // bits of the written value. The model copy is updated in the same call.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] kept;
    bit          mapped;
    mapped = 1'b1;
    kept   = '0;
    case (idx)
      REG_FRAME_W:  begin reg_frame_w  = val[EDGE_W-1:0];  kept = 32'(reg_frame_w);  end
      REG_FRAME_H:  begin reg_frame_h  = val[EDGE_W-1:0];  kept = 32'(reg_frame_h);  end
      REG_W_SCALE:  begin reg_w_scale  = val[SCALE_W-1:0]; kept = 32'(reg_w_scale);  end
      REG_H_SCALE:  begin reg_h_scale  = val[SCALE_W-1:0]; kept = 32'(reg_h_scale);  end
      REG_MIN_H:    begin reg_min_h    = val[EDGE_W-1:0];  kept = 32'(reg_min_h);    end
      REG_LOSS_LIM: begin reg_loss_lim = val[MISS_W-1:0];  kept = 32'(reg_loss_lim); end
      default:      mapped = 1'b0;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    n_cfg_writes++;
    if (mapped) begin
      @(negedge clk);
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      check_field("register readback", kept, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Waits until every queued transfer has been taken and every result has
  // come back, then waits out a settling pause so the sequencer is idle.
  task automatic wait_idle();
    while (send_q.size() != 0 || sending || window_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender. With gaps on, items go out in bursts of random length with random
  // gaps in between. The model runs at the edge where a transfer is accepted,
  // so its state always follows the order in which the block takes items.
  // --------------------------------------------------------------------------
  initial begin : sender
    tx_item_t    cur;
    win_result_t pred;
    int          burst_left;
    int          gap_left;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (gap_left > 0 || send_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur       = send_q.pop_front();
        sending   = 1'b1;
        in_tvalid <= 1'b1;
        in_tdata  <= cur.corners;
        in_tuser  <= cur.kind;
        do @(posedge clk); while (!in_tready);
        pred = predict_window(cur.kind, cur.corners);
        window_q.push_back(cur.has_typed ? cur.typed_res : pred);
        if (cur.kind == KIND_FEEDBACK) n_feedback++;
        else n_request++;
        sending = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0 && gaps_on) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 24);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. With stalls on, it alternates runs of ready and stalled cycles
  // of random length, unrelated to the sender; else it is always ready. On
  // request it holds off for a long stretch that it counts itself, so that
  // the result register stays full and the block has to stall its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int run_left;
    int hold_left;
    bit level;
    out_tready = 1'b0;
    run_left   = 0;
    hold_left  = 0;
    level      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!rx_stalls_on) begin
        out_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level    = ~level;
          run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 12);
        end
        run_left--;
        out_tready <= level;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    win_result_t exp_res;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      if (window_q.size() == 0) begin
        $display("%0t: result with none expected, actual tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_res = window_q.pop_front();
        n_results++;
        if (exp_res.full) n_fallback++;
        check_field("win_left",   exp_res.w_left,   out_tdata[11:0]);
        check_field("win_top",    exp_res.w_top,    out_tdata[23:12]);
        check_field("win_right",  exp_res.w_right,  out_tdata[35:24]);
        check_field("win_bottom", exp_res.w_bottom, out_tdata[47:36]);
        check_field("misses",     exp_res.misses,   out_tdata[63:48]);
        check_field("full_frame", exp_res.full,     out_tuser);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, window_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, top-limit run.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    dir_row_t     row;
    logic [127:0] w;
    logic [31:0]  v;
    int           phase;
    int           queued;
    int           nreq;
    int           mode;
    int           cx, cy, hwd, hht;
    int           xl, xr, yt, yb;
    corner_pick_t pick;

    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    sending      = 1'b0;
    gaps_on      = 1'b1;
    rx_stalls_on = 1'b1;
    hold_req     = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    n_feedback   = 0;
    n_request    = 0;
    n_fallback   = 0;
    n_results    = 0;
    n_cfg_writes = 0;

    // Model state as it stands after reset.
    reg_frame_w  = RST_FRAME_W;
    reg_frame_h  = RST_FRAME_H;
    reg_w_scale  = RST_W_SCALE;
    reg_h_scale  = RST_H_SCALE;
    reg_min_h    = RST_MIN_H;
    reg_loss_lim = RST_LOSS_LIM;
    win_valid    = 1'b0;
    miss_cnt     = '0;
    edge_l       = '0;
    edge_t       = '0;
    edge_r       = RST_FRAME_W;
    edge_b       = RST_FRAME_H;

    // Directed table. Under the reset setting, requests with no window must
    // give the full frame. A target of zero size is held open by the minimum
    // height alone. Corners all at the most negative value give edges at 0.
    directed_rows.push_back(typed_row(KIND_REQUEST, '0, win_res(0, 0, 1280, 1024, 1, 0)));
    directed_rows.push_back(typed_row(KIND_REQUEST, '1, win_res(0, 0, 1280, 1024, 1, 0)));
    directed_rows.push_back(typed_row(KIND_FEEDBACK, '0, win_res(0, 0, 0, 200, 0, 0)));
    directed_rows.push_back(item_row(KIND_FEEDBACK,
        corner_word(1600, 1600, 3200, 1600, 3200, 2400, 1600, 2400)));
    directed_rows.push_back(item_row(KIND_REQUEST, {4{32'h5555_AAAA}}));
    directed_rows.push_back(typed_row(KIND_FEEDBACK, {8{16'h8000}},
        win_res(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(item_row(KIND_FEEDBACK, {8{16'h7FFF}}));
    directed_rows.push_back(item_row(KIND_FEEDBACK,
        corner_word(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767)));
    directed_rows.push_back(item_row(KIND_FEEDBACK, {8{16'h5555}}));
    directed_rows.push_back(item_row(KIND_FEEDBACK, {8{16'hAAAA}}));
    // Largest frame and scales, and a loss limit of zero: the second request
    // after a detection already falls back.
    directed_rows.push_back(cfg_row(REG_FRAME_W, 32'd4095));
    directed_rows.push_back(cfg_row(REG_FRAME_H, 32'd4095));
    directed_rows.push_back(cfg_row(REG_W_SCALE, 32'd15));
    directed_rows.push_back(cfg_row(REG_H_SCALE, 32'd15));
    directed_rows.push_back(cfg_row(REG_MIN_H, 32'd4095));
    directed_rows.push_back(cfg_row(REG_LOSS_LIM, 32'd0));
    directed_rows.push_back(item_row(KIND_FEEDBACK,
        corner_word(1600, 1600, 3200, 1600, 3200, 2400, 1600, 2400)));
    directed_rows.push_back(item_row(KIND_REQUEST, '1));
    directed_rows.push_back(typed_row(KIND_REQUEST, '0, win_res(0, 0, 4095, 4095, 1, 0)));
    directed_rows.push_back(typed_row(KIND_REQUEST, '0, win_res(0, 0, 4095, 4095, 1, 0)));
    // A frame of zero size, written through values whose upper bits must be
    // dropped, clamps every edge to 0. The unmapped indexes must change
    // nothing.
    directed_rows.push_back(cfg_row(REG_FRAME_W, 32'h0000_1000));
    directed_rows.push_back(cfg_row(REG_FRAME_H, 32'hFFFF_F000));
    directed_rows.push_back(cfg_row(REG_W_SCALE, 32'd0));
    directed_rows.push_back(cfg_row(REG_H_SCALE, 32'hFFFF_FFF0));
    directed_rows.push_back(cfg_row(REG_MIN_H, 32'd0));
    directed_rows.push_back(cfg_row(REG_LOSS_LIM, 32'h0001_0003));
    directed_rows.push_back(cfg_row(UNMAPPED_REG_LO, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(UNMAPPED_REG_HI, 32'h0000_0001));
    directed_rows.push_back(typed_row(KIND_FEEDBACK,
        corner_word(1600, 1600, 3200, 1600, 3200, 2400, 1600, 2400),
        win_res(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(typed_row(KIND_REQUEST, '0, win_res(0, 0, 0, 0, 0, 1)));
    directed_rows.push_back(item_row(KIND_FEEDBACK, {8{16'h7FFF}}));
    // A small frame and a loss limit of two: three misses are counted, the
    // fourth request falls back.
    directed_rows.push_back(cfg_row(REG_FRAME_W, 32'd640));
    directed_rows.push_back(cfg_row(REG_FRAME_H, 32'd480));
    directed_rows.push_back(cfg_row(REG_W_SCALE, 32'd1));
    directed_rows.push_back(cfg_row(REG_H_SCALE, 32'd2));
    directed_rows.push_back(cfg_row(REG_MIN_H, 32'd8));
    directed_rows.push_back(cfg_row(REG_LOSS_LIM, 32'd2));
    directed_rows.push_back(item_row(KIND_FEEDBACK,
        corner_word(1600, 1600, 3200, 1600, 3200, 2400, 1600, 2400)));
    directed_rows.push_back(item_row(KIND_FEEDBACK,
        corner_word(1600, 800, 3200, 1600, 2400, 3200, 800, 2400)));
    directed_rows.push_back(item_row(KIND_REQUEST, '0));
    directed_rows.push_back(item_row(KIND_REQUEST, '1));
    directed_rows.push_back(item_row(KIND_REQUEST, {4{32'hA5A5_5A5A}}));
    directed_rows.push_back(typed_row(KIND_REQUEST, '0, win_res(0, 0, 640, 480, 1, 0)));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register writes only go out once the block has drained.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        wait_idle();
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        send_q.push_back(row.item);
      end
    end

    // Random phases. Each one programs every register, with the extremes
    // picked now and then and junk in the unused upper bits, and then feeds
    // tracks: a detection, or none, followed by a run of requests, long
    // enough to reach the fallback where the loss limit is small.
    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       v = 32'd4095;
        1:       v = 32'd1;
        default: v = $urandom_range(320, 2047);
      endcase
      cfg_write(REG_FRAME_W, ($urandom() & 32'hFFFF_F000) | v);
      case ($urandom_range(0, 4))
        0:       v = 32'd4095;
        1:       v = 32'd1;
        default: v = $urandom_range(240, 2047);
      endcase
      cfg_write(REG_FRAME_H, ($urandom() & 32'hFFFF_F000) | v);
      cfg_write(REG_W_SCALE, ($urandom() & 32'hFFFF_FFF0) | $urandom_range(0, 15));
      cfg_write(REG_H_SCALE, ($urandom() & 32'hFFFF_FFF0) | $urandom_range(0, 15));
      case ($urandom_range(0, 5))
        0:       v = 32'd0;
        1:       v = 32'd4095;
        default: v = $urandom_range(0, 120);
      endcase
      cfg_write(REG_MIN_H, ($urandom() & 32'hFFFF_F000) | v);
      case ($urandom_range(0, 6))
        0:       v = 32'd0;
        1:       v = 32'd65534;
        2:       v = $urandom_range(0, 65535);
        default: v = $urandom_range(0, 12);
      endcase
      cfg_write(REG_LOSS_LIM, ($urandom() & 32'hFFFF_0000) | v);
      cfg_write($urandom_range(0, 1) ? UNMAPPED_REG_LO : UNMAPPED_REG_HI, $urandom());

      // Vary the idling between phases, with some stretches free of it.
      gaps_on      = (phase % 4 != 1);
      rx_stalls_on = (phase % 4 != 2);
      if (phase == 3) begin
        // Back-to-back offers against a receiver that holds off for long.
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end

      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
          // A roughly rectangular target with sub-pixel jitter on each corner.
          cx  = int'($urandom_range(0, 2100)) - 50;
          cy  = int'($urandom_range(0, 2100)) - 50;
          hwd = $urandom_range(1, 300);
          hht = $urandom_range(1, 200);
          xl  = (cx - hwd) * 16;
          xr  = (cx + hwd) * 16;
          yt  = (cy - hht) * 16;
          yb  = (cy + hht) * 16;
          w = corner_word(xl + int'($urandom_range(0, 31)) - 16,
                          yt + int'($urandom_range(0, 31)) - 16,
                          xr + int'($urandom_range(0, 31)) - 16,
                          yt + int'($urandom_range(0, 31)) - 16,
                          xr + int'($urandom_range(0, 31)) - 16,
                          yb + int'($urandom_range(0, 31)) - 16,
                          xl + int'($urandom_range(0, 31)) - 16,
                          yb + int'($urandom_range(0, 31)) - 16);
          push_item(KIND_FEEDBACK, w);
          queued++;
        end else if (mode == 7) begin
          // Corners of any value at all.
          push_item(KIND_FEEDBACK, {$urandom(), $urandom(), $urandom(), $urandom()});
          queued++;
        end else if (mode == 8) begin
          // Each coordinate at one of the extremes of its range.
          for (int k = 0; k < 8; k++) begin
            pick = corner_pick_t'($urandom_range(0, 3));
            case (pick)
              PICK_MIN:  w[16*k +: 16] = 16'h8000;
              PICK_MAX:  w[16*k +: 16] = 16'h7FFF;
              PICK_ZERO: w[16*k +: 16] = 16'h0000;
              default:   w[16*k +: 16] = 16'hFFFF;
            endcase
          end
          push_item(KIND_FEEDBACK, w);
          queued++;
        end
        // Then a run of requests; in mode 9 it stands alone with no detection before it.
        nreq = (reg_loss_lim < 16) ? $urandom_range(0, reg_loss_lim + 3)
                                   : $urandom_range(0, 6);
        for (int k = 0; k < nreq; k++) begin
          push_item(KIND_REQUEST, {$urandom(), $urandom(), $urandom(), $urandom()});
        end
        queued += nreq;
      end
    end

    // Top-limit run: with the loss limit at its top the miss counter keeps
    // climbing with no fallback. Lowering the limit below the count then
    // forces the fallback on the next request.
    wait_idle();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    cfg_write(REG_LOSS_LIM, 32'hFFFF_FFFF);
    push_item(KIND_FEEDBACK, corner_word(3200, 3200, 6400, 3200, 6400, 4800, 3200, 4800));
    for (int k = 0; k < TOP_LIM_REQUESTS; k++) begin
      push_item(KIND_REQUEST, {$urandom(), $urandom(), $urandom(), $urandom()});
    end
    wait_idle();
    cfg_write(REG_LOSS_LIM, 32'd3);
    push_item(KIND_REQUEST, '0);
    push_item(KIND_REQUEST, '1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d feedback and %0d request transfers, %0d register writes.",
             n_feedback, n_request, n_cfg_writes);
    $display("%0d results compared, %0d of them full-frame fallbacks; %0d mismatches.",
             n_results, n_fallback, errors);
    if (errors == 0 && window_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> roi_window_tracker_core.f
+incdir+src
src/roi_pkg.sv
src/roi_isqrt.sv
src/roi_edge.sv
src/roi_window_tracker_core.sv
verif/tb_roi_window_tracker_core.sv
